>>> rtl/itap_pkg.sv
// itap_pkg: shared types and constants of the ipv6 text address parser
// no dependencies; imported by every module under rtl
package itap_pkg;

  localparam int unsigned GROUP_COUNT = 8;
  localparam int unsigned MAX_DIGITS  = 4;
  localparam int unsigned GROUP_W     = 16;
  localparam int unsigned GIDX_W      = 3;
  localparam int unsigned DCNT_W      = 3;
  localparam int unsigned ERR_W       = 3;
  localparam int unsigned OUT_DATA_W  = 136;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;

  typedef enum logic [1:0] {
    CK_HEX,
    CK_COLON,
    CK_DASH,
    CK_OTHER
  } char_kind_e;

  typedef enum logic [1:0] {
    PH_START,
    PH_PREFIX,
    PH_BODY
  } phase_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE        = 3'd0,
    ERR_PREFIX_LONG = 3'd1,
    ERR_PREFIX_BAD  = 3'd2,
    ERR_GROUP_LONG  = 3'd3,
    ERR_COLONS      = 3'd4,
    ERR_GROUPS      = 3'd5,
    ERR_EMPTY       = 3'd6,
    ERR_CHAR        = 3'd7
  } err_e;

  // one classified character as it sits in the queue
  typedef struct packed {
    logic       is_last;
    char_kind_e kind;
    logic [3:0] digit;
  } chr_item_t;

endpackage

>>> rtl/itap_classify.sv
// itap_classify: front end, sorts each character into hex digit, colon, dash or other
// depends on itap_pkg
module itap_classify (
  input  logic [7:0]          char_i,
  input  logic                last_i,
  output itap_pkg::chr_item_t item_o
);
  import itap_pkg::*;

  always_comb begin
    item_o.is_last = last_i;
    item_o.digit   = 4'd0;
    item_o.kind    = CK_OTHER;
    if (char_i >= 8'h30 && char_i <= 8'h39) begin
      item_o.kind  = CK_HEX;
      item_o.digit = char_i[3:0];
    end else if ((char_i >= 8'h61 && char_i <= 8'h66) ||
                 (char_i >= 8'h41 && char_i <= 8'h46)) begin
      // 'a'..'f' and 'A'..'F' share the low three bits: 1..6
      item_o.kind  = CK_HEX;
      item_o.digit = 4'd9 + {1'b0, char_i[2:0]};
    end else if (char_i == CHAR_COLON) begin
      item_o.kind = CK_COLON;
    end else if (char_i == CHAR_DASH) begin
      item_o.kind = CK_DASH;
    end
  end

endmodule

>>> rtl/itap_fifo.sv
// itap_fifo: short queue of classified characters between front and back end
// depends on itap_pkg
module itap_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  output logic                wr_ready_o,
  input  itap_pkg::chr_item_t wr_item_i,
  output logic                rd_valid_o,
  input  logic                rd_ready_i,
  output itap_pkg::chr_item_t rd_item_o
);
  import itap_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  chr_item_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr, rd;

  assign wr_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign wr         = wr_valid_i && wr_ready_o;
  assign rd         = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({wr, rd})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

>>> rtl/itap_parse.sv
// itap_parse: back end, runs the prefix/body parser, places the groups and holds the result
// depends on itap_pkg
module itap_parse (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           item_valid_i,
  output logic                           item_ready_o,
  input  itap_pkg::chr_item_t            item_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [itap_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import itap_pkg::*;

  logic [GROUP_W-1:0] grp_q [GROUP_COUNT];
  logic [GROUP_W-1:0] grp_d [GROUP_COUNT];
  logic [GROUP_COUNT-1:0] has_q, has_d;
  logic [GIDX_W-1:0]  gi_q, gi_d, gap_q, gap_d;
  logic [DCNT_W-1:0]  dc_q, dc_d;
  logic [1:0]         colon_q, colon_d;
  logic [GROUP_W-1:0] fill_q, fill_d;
  phase_e             phase_q, phase_d;
  err_e               err_q, err_d;

  logic               out_valid_q, out_valid_d;
  logic [GROUP_W-1:0] out_grp_q [GROUP_COUNT];
  logic [GROUP_W-1:0] res [GROUP_COUNT];
  err_e               out_err_q, fin_err;

  logic pop, do_body, empty_grp;

  assign item_ready_o = !item_i.is_last || !out_valid_q || m_axis_tready_i;
  assign pop          = item_valid_i && item_ready_o;

  // parser step
  always_comb begin
    grp_d   = grp_q;
    has_d   = has_q;
    gi_d    = gi_q;
    gap_d   = gap_q;
    dc_d    = dc_q;
    colon_d = colon_q;
    fill_d  = fill_q;
    phase_d = phase_q;
    err_d   = err_q;
    do_body = 1'b0;
    if (pop && err_q == ERR_NONE) begin
      unique case (phase_q)
        PH_START: begin
          if (item_i.kind == CK_DASH) begin
            phase_d = PH_PREFIX;
          end else begin
            phase_d = PH_BODY;
            do_body = 1'b1;
          end
        end
        PH_PREFIX: begin
          if (item_i.kind == CK_DASH) begin
            if (dc_q == '0) begin
              err_d = ERR_PREFIX_BAD;
            end else begin
              phase_d = PH_BODY;
              dc_d    = '0;
            end
          end else if (dc_q >= DCNT_W'(MAX_DIGITS)) begin
            err_d = ERR_PREFIX_LONG;
          end else if (item_i.kind != CK_HEX) begin
            err_d = ERR_PREFIX_BAD;
          end else begin
            fill_d = {fill_q[GROUP_W-5:0], item_i.digit};
            dc_d   = dc_q + 1'b1;
          end
        end
        default: do_body = 1'b1;
      endcase
    end
    if (do_body) begin
      if (item_i.kind == CK_COLON) begin
        if (colon_q == 2'd0) begin
          if (gi_q == GIDX_W'(GROUP_COUNT - 1)) begin
            err_d = ERR_GROUPS;
          end else begin
            gi_d    = gi_q + 1'b1;
            dc_d    = '0;
            colon_d = 2'd1;
          end
        end else if (colon_q == 2'd1 && gap_q == '0) begin
          gap_d   = gi_q;
          colon_d = 2'd2;
        end else begin
          err_d = ERR_COLONS;
        end
      end else if (item_i.kind != CK_HEX) begin
        err_d = ERR_CHAR;
      end else if (dc_q >= DCNT_W'(MAX_DIGITS)) begin
        err_d = ERR_GROUP_LONG;
      end else begin
        for (int k = 0; k < GROUP_COUNT; k++) begin
          if (GIDX_W'(k) == gi_q) begin
            grp_d[k] = {grp_q[k][GROUP_W-5:0], item_i.digit};
            has_d[k] = 1'b1;
          end
        end
        dc_d    = dc_q + 1'b1;
        colon_d = 2'd0;
      end
    end
  end

  // end-of-address checks and group placement on the stepped state
  always_comb begin
    logic [GIDX_W:0]   sum;
    logic [GIDX_W-1:0] src;
    empty_grp = 1'b0;
    for (int i = 0; i < GROUP_COUNT; i++) begin
      if (GIDX_W'(i) <= gi_d && !has_d[i] &&
          !(i == 0 && gap_d == GIDX_W'(1)) &&
          !(GIDX_W'(i) == gi_d && gap_d != '0 && gap_d == gi_d)) begin
        empty_grp = 1'b1;
      end
    end
    fin_err = err_d;
    if (fin_err == ERR_NONE && phase_d != PH_BODY) begin
      fin_err = ERR_PREFIX_BAD;
    end else if (fin_err == ERR_NONE && empty_grp) begin
      fin_err = ERR_EMPTY;
    end
    for (int j = 0; j < GROUP_COUNT; j++) begin
      res[j] = fill_d;
      // groups ahead of the gap keep their place
      if (GIDX_W'(j) < gap_d && GIDX_W'(j) <= gi_d && has_d[j]) begin
        res[j] = grp_d[j];
      end
      // groups from the gap on are right-aligned
      sum = {1'b0, GIDX_W'(j)} + {1'b0, gi_d} + 1'b1;
      src = sum[GIDX_W-1:0];
      if (sum[GIDX_W] && src >= gap_d && has_d[src]) begin
        res[j] = grp_d[src];
      end
      if (fin_err != ERR_NONE) begin
        res[j] = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop && item_i.is_last) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < GROUP_COUNT; k++) begin
        grp_q[k] <= '0;
      end
      has_q       <= '0;
      gi_q        <= '0;
      gap_q       <= '0;
      dc_q        <= '0;
      colon_q     <= '0;
      fill_q      <= '0;
      phase_q     <= PH_START;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop && item_i.is_last) begin
        // address done, back to the reset state
        for (int k = 0; k < GROUP_COUNT; k++) begin
          grp_q[k] <= '0;
        end
        has_q   <= '0;
        gi_q    <= '0;
        gap_q   <= '0;
        dc_q    <= '0;
        colon_q <= '0;
        fill_q  <= '0;
        phase_q <= PH_START;
        err_q   <= ERR_NONE;
      end else begin
        grp_q   <= grp_d;
        has_q   <= has_d;
        gi_q    <= gi_d;
        gap_q   <= gap_d;
        dc_q    <= dc_d;
        colon_q <= colon_d;
        fill_q  <= fill_d;
        phase_q <= phase_d;
        err_q   <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && item_i.is_last) begin
      out_grp_q <= res;
      out_err_q <= fin_err;
    end
  end

  always_comb begin
    m_axis_tdata_o = '0;
    for (int j = 0; j < GROUP_COUNT; j++) begin
      m_axis_tdata_o[j*GROUP_W +: GROUP_W] = out_grp_q[j];
    end
    m_axis_tdata_o[GROUP_COUNT*GROUP_W +: ERR_W] = out_err_q;
  end

  assign m_axis_tvalid_o = out_valid_q;

endmodule

>>> rtl/ipv6_text_address_parser.sv
// ipv6_text_address_parser: top level, character classifier, queue and parser back end
// depends on itap_pkg, itap_classify, itap_fifo, itap_parse
//
// usage
//   slave side: one ascii character per beat on s_axis_tdata_i, s_axis_tlast_i high on
//   the last character of an address. an optional leading "-hex-" sets the fill value
//   for groups the text does not name (zero otherwise)
//   master side: one beat per address, sent for the last character only, carrying the
//   eight 16-bit groups and a 3-bit error code (first error seen; groups all zero on error)
// throughput: one character per cycle, set by the parser step in the back end, unless a
//   last character waits on a held result beat; the queue keeps the slave side open
//   while a result beat waits. path: a last character is written into the queue, and the
//   parser step loads the output register with its result as it pops it from the queue
// reset: queue empty, parser at the start of an address, no result beat pending
// stall: while m_axis_tready_i is low a held result blocks only the next last character;
//   ordinary characters keep flowing until the queue fills, then s_axis_tready_o drops
module ipv6_text_address_parser #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,  // [7:0] character
  input  logic                            s_axis_tlast_i,  // is_last
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [15:0] group_0, [31:16] group_1 ... [127:112] group_7, [130:128] error_code,
  // [135:131] zero
  output logic [itap_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import itap_pkg::*;

  chr_item_t cls_item, q_item;
  logic      q_valid, q_ready;

  // front: character classes
  itap_classify u_classify (
    .char_i (s_axis_tdata_i),
    .last_i (s_axis_tlast_i),
    .item_o (cls_item)
  );

  // queue parting front and back
  itap_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (s_axis_tvalid_i),
    .wr_ready_o (s_axis_tready_o),
    .wr_item_i  (cls_item),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_item_o  (q_item)
  );

  // back: parser state, group placement, result register
  itap_parse u_parse (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (q_valid),
    .item_ready_o    (q_ready),
    .item_i          (q_item),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // an error result never carries group data
  a_err_zero_groups : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[GROUP_COUNT*GROUP_W +: ERR_W] != ERR_NONE |->
      m_axis_tdata_o[GROUP_COUNT*GROUP_W-1:0] == '0)
    else $error("error result with non-zero groups");

  // a last character taken by the back end always produces a result beat
  a_last_gives_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && q_ready && q_item.is_last |=> m_axis_tvalid_o)
    else $error("last character consumed without a result beat");

  // an accepted beat is visible to the back end in the next cycle
  a_beat_queued : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> q_valid)
    else $error("accepted beat missing from queue");

endmodule

>>> sim/tb_ipv6_text_address_parser.sv
// tb_ipv6_text_address_parser: self-checking testbench for the ipv6 text address parser
// depends on itap_pkg and ipv6_text_address_parser; streams address text, predicts and
// checks every result beat against an in-bench parser under random idling on both sides
module tb_ipv6_text_address_parser;
  import itap_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_CHARS = 1150;
  localparam int unsigned REPORT_MAX = 10;

  // one character beat waiting to go out; hold marks a wait for all results first
  typedef struct packed {
    logic [7:0] chr;
    logic       last;
    logic       hold;
  } text_beat_t;

  typedef struct packed {
    logic [GROUP_COUNT-1:0][GROUP_W-1:0] grp;
    err_e                                err;
  } addr_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'h00;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  ipv6_text_address_parser i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),   // [7:0] character
    .s_axis_tlast_i (s_axis_tlast),   // is_last
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    // [15:0] group_0 ... [127:112] group_7, [130:128] error_code, [135:131] zero
    .m_axis_tdata_o (m_axis_tdata)
  );

  text_beat_t   text_beats_q[$];
  addr_result_t addr_expected_q[$];
  logic [7:0]   addr_text[$];
  text_beat_t   beat_on_bus;
  text_beat_t   beat_next;
  addr_result_t result_want;
  int unsigned  n_accepted = 0;
  int unsigned  n_total = 0;
  int unsigned  n_fail = 0;
  int unsigned  n_addr = 0;

  // parser state of the prediction
  logic [GROUP_W-1:0] pr_grp[GROUP_COUNT];
  logic               pr_has[GROUP_COUNT];
  int unsigned        pr_gidx;
  int unsigned        pr_dcnt;
  int unsigned        pr_colons;
  int unsigned        pr_gap;
  logic [GROUP_W-1:0] pr_fill;
  phase_e             pr_phase;
  err_e               pr_err;

  function automatic int unsigned hex_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return 16;
  endfunction

  function void clear_parser();
    for (int i = 0; i < GROUP_COUNT; i++) begin
      pr_grp[i] = '0;
      pr_has[i] = 1'b0;
    end
    pr_gidx   = 0;
    pr_dcnt   = 0;
    pr_colons = 0;
    pr_gap    = 0;
    pr_fill   = '0;
    pr_phase  = PH_START;
    pr_err    = ERR_NONE;
  endfunction

  // only the first error of an address survives
  function void raise_err(err_e e);
    if (pr_err == ERR_NONE) pr_err = e;
  endfunction

  function void parse_body_char(logic [7:0] c);
    int unsigned d;
    if (c == CHAR_COLON) begin
      if (pr_colons == 0) begin
        if (pr_gidx + 1 >= GROUP_COUNT) begin
          raise_err(ERR_GROUPS);
          return;
        end
        pr_gidx++;
        pr_dcnt   = 0;
        pr_colons = 1;
      end else if (pr_colons == 1) begin
        // a second "::" is as bad as ":::"
        if (pr_gap != 0) begin
          raise_err(ERR_COLONS);
          return;
        end
        pr_gap    = pr_gidx;
        pr_colons = 2;
      end else begin
        raise_err(ERR_COLONS);
      end
      return;
    end
    d = hex_of(c);
    if (d > 15) begin
      raise_err(ERR_CHAR);
      return;
    end
    if (pr_dcnt >= MAX_DIGITS) begin
      raise_err(ERR_GROUP_LONG);
      return;
    end
    pr_grp[pr_gidx] = {pr_grp[pr_gidx][GROUP_W-5:0], d[3:0]};
    pr_has[pr_gidx] = 1'b1;
    pr_dcnt++;
    pr_colons = 0;
  endfunction

  function void parse_char(logic [7:0] c);
    int unsigned d;
    if (pr_err != ERR_NONE) return;
    case (pr_phase)
      PH_START: begin
        if (c == CHAR_DASH) pr_phase = PH_PREFIX;
        else begin
          pr_phase = PH_BODY;
          parse_body_char(c);
        end
      end
      PH_PREFIX: begin
        if (c == CHAR_DASH) begin
          if (pr_dcnt == 0) raise_err(ERR_PREFIX_BAD);
          else begin
            pr_phase = PH_BODY;
            pr_dcnt  = 0;
          end
        end else if (pr_dcnt >= MAX_DIGITS) begin
          raise_err(ERR_PREFIX_LONG);
        end else begin
          d = hex_of(c);
          if (d > 15) raise_err(ERR_PREFIX_BAD);
          else begin
            pr_fill = {pr_fill[GROUP_W-5:0], d[3:0]};
            pr_dcnt++;
          end
        end
      end
      default: parse_body_char(c);
    endcase
  endfunction

  // end of address: check for empty groups, place groups around the gap
  function void close_address();
    addr_result_t r;
    int unsigned  dest;
    if (pr_err == ERR_NONE && pr_phase != PH_BODY) raise_err(ERR_PREFIX_BAD);
    if (pr_err == ERR_NONE) begin
      for (int unsigned i = 0; i <= pr_gidx; i++) begin
        if (!pr_has[i] && !(i == 0 && pr_gap == 1)
            && !(i == pr_gidx && pr_gap != 0 && pr_gap == pr_gidx)) begin
          raise_err(ERR_EMPTY);
          break;
        end
      end
    end
    for (int i = 0; i < GROUP_COUNT; i++) r.grp[i] = pr_fill;
    if (pr_err == ERR_NONE) begin
      for (int unsigned i = 0; i <= pr_gidx; i++) begin
        if (pr_has[i]) begin
          dest = (i < pr_gap) ? i : (GROUP_COUNT - 1) + i - pr_gidx;
          if (dest < GROUP_COUNT) r.grp[dest] = pr_grp[i];
        end
      end
    end else begin
      r.grp = '0;
    end
    r.err = pr_err;
    addr_expected_q.push_back(r);
    clear_parser();
  endfunction

  function void predict_beat(text_beat_t b);
    parse_char(b.chr);
    if (b.last) close_address();
  endfunction

  // idling shares: sender 20 / receiver 61, then swapped, then none
  function automatic int unsigned idle_pct(bit sender);
    int unsigned ph;
    ph = (n_total == 0) ? 0 : n_accepted * 3 / n_total;
    if (ph == 0) return sender ? 20 : 61;
    if (ph == 1) return sender ? 61 : 20;
    return 0;
  endfunction

  // ---------------------------------------------------------------- stimulus text

  function automatic logic [7:0] hex_char(int unsigned v);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
  endfunction

  function void put_group(int unsigned ndig);
    for (int unsigned i = 0; i < ndig; i++) addr_text.push_back(hex_char($urandom_range(15)));
  endfunction

  function automatic int unsigned group_len();
    // an over-long group now and then
    return ($urandom_range(24) == 0) ? 5 : $urandom_range(1, 4);
  endfunction

  function void load_string(string s);
    addr_text.delete();
    for (int i = 0; i < s.len(); i++) addr_text.push_back(s[i]);
  endfunction

  function void build_well_formed();
    int unsigned k;
    int unsigned p;
    addr_text.delete();
    if ($urandom_range(3) == 0) begin
      addr_text.push_back(CHAR_DASH);
      put_group($urandom_range(1, 4));
      addr_text.push_back(CHAR_DASH);
    end
    if ($urandom_range(1)) begin
      // with a gap; eight named groups plus a gap runs out of room
      k = ($urandom_range(9) == 0) ? 8 : $urandom_range(0, 7);
      p = $urandom_range(0, k);
      for (int unsigned i = 0; i < p; i++) begin
        if (i > 0) addr_text.push_back(CHAR_COLON);
        put_group(group_len());
      end
      addr_text.push_back(CHAR_COLON);
      addr_text.push_back(CHAR_COLON);
      for (int unsigned i = p; i < k; i++) begin
        if (i > p) addr_text.push_back(CHAR_COLON);
        put_group(group_len());
      end
    end else begin
      k = ($urandom_range(15) == 0) ? 9 : $urandom_range(1, 8);
      for (int unsigned i = 0; i < k; i++) begin
        if (i > 0) addr_text.push_back(CHAR_COLON);
        put_group(group_len());
      end
    end
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(4))
      0: return CHAR_COLON;
      1: return CHAR_DASH;
      2: return hex_char($urandom_range(15));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function void build_broken();
    int unsigned pos;
    int unsigned mode;
    mode = $urandom_range(3);
    if (mode == 3) begin
      addr_text.delete();
      repeat ($urandom_range(1, 10)) addr_text.push_back(noise_char());
      return;
    end
    build_well_formed();
    pos = $urandom_range(addr_text.size() - 1);
    if (mode == 0) addr_text[pos] = noise_char();
    else if (mode == 1) addr_text.insert(pos, noise_char());
    else if (addr_text.size() > 1) addr_text.delete(pos);
  endfunction

  function void queue_address(bit hold);
    text_beat_t b;
    for (int i = 0; i < addr_text.size(); i++) begin
      b.chr  = addr_text[i];
      b.last = (i == addr_text.size() - 1);
      b.hold = hold && (i == 0);
      text_beats_q.push_back(b);
    end
    n_addr++;
  endfunction

  // ---------------------------------------------------------------- clock and driver

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // slave side: a beat is taken when valid and ready meet, then the next one goes up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        predict_beat(beat_on_bus);
        n_accepted++;
      end
      if (text_beats_q.size() != 0
          && !(text_beats_q[0].hold && addr_expected_q.size() != 0)
          && $urandom_range(99) >= idle_pct(1'b1)) begin
        beat_next     = text_beats_q.pop_front();
        beat_on_bus   = beat_next;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat_next.chr;
        s_axis_tlast  <= beat_next.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // master side back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b0));
  end

  // ---------------------------------------------------------------- monitor

  task automatic note_mismatch(string field, logic [15:0] want, logic [15:0] got);
    n_fail++;
    if (n_fail <= REPORT_MAX)
      $display("mismatch %s: expected %h, got %h", field, want, got);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (addr_expected_q.size() == 0) begin
        n_fail++;
        if (n_fail <= REPORT_MAX) $display("result beat with nothing expected: %h", m_axis_tdata);
      end else begin
        result_want = addr_expected_q.pop_front();
        for (int i = 0; i < GROUP_COUNT; i++) begin
          if (m_axis_tdata[i*GROUP_W +: GROUP_W] !== result_want.grp[i])
            note_mismatch($sformatf("group_%0d", i), result_want.grp[i],
                          m_axis_tdata[i*GROUP_W +: GROUP_W]);
        end
        if (m_axis_tdata[130:128] !== result_want.err)
          note_mismatch("error_code", 16'(result_want.err), 16'(m_axis_tdata[130:128]));
        if (m_axis_tdata[OUT_DATA_W-1:131] !== '0)
          note_mismatch("padding", 16'h0, 16'(m_axis_tdata[OUT_DATA_W-1:131]));
      end
    end
  end

  // ---------------------------------------------------------------- timeout

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("FAIL ipv6_text_address_parser");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    clear_parser();

    // directed: double colon alone, prefix fill with a short address, extremes
    load_string("::");
    queue_address(1'b0);
    load_string("-ffff-8");
    queue_address(1'b0);
    load_string("-12345");        // prefix too long
    queue_address(1'b0);
    load_string("-");             // text ends inside the prefix
    queue_address(1'b0);
    load_string("FfFf0");         // group too long
    queue_address(1'b0);
    load_string(":::");           // too many colons
    queue_address(1'b0);
    load_string("f:f:f:f:f:f:f:f:");  // separator for a ninth group
    queue_address(1'b0);
    load_string("1:");            // trailing empty group
    queue_address(1'b0);
    addr_text.delete();
    addr_text.push_back(8'h00);   // nul in the body
    queue_address(1'b0);

    // random: mostly well-formed text, the rest broken; hold-offs now and then
    while (text_beats_q.size() < RANDOM_CHARS) begin
      if ($urandom_range(3) == 0) build_broken();
      else build_well_formed();
      queue_address(n_addr == 9 || n_addr % 100 == 0);
    end
    n_total = text_beats_q.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (text_beats_q.size() != 0 || s_axis_tvalid || addr_expected_q.size() != 0)
      @(posedge clk_i);
    // then go on to catch stray result beats
    repeat (10) @(posedge clk_i);

    if (n_fail == 0 && addr_expected_q.size() == 0) begin
      $display("PASS ipv6_text_address_parser");
    end else begin
      $display("FAIL ipv6_text_address_parser");
    end
    $finish;
  end

endmodule
